### rtl/core/assert_macros.svh
// Assertion macros shared by the shortest path core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle check failed");

`endif

### rtl/core/ssp_pkg.sv
// Shared types, sizes and codes of the shortest path core.
package ssp_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int MAX_EDGES    = 64;
    localparam int WEIGHT_BITS  = 16;

    localparam int VTX_W  = $clog2(MAX_VERTICES);
    localparam int EDGE_W = $clog2(MAX_EDGES);
    localparam int ECNT_W = EDGE_W + 1;
    localparam int IDX_W  = (EDGE_W > VTX_W) ? EDGE_W : VTX_W;
    localparam int CNT_W  = 7;
    localparam int DIST_W = 22;
    localparam int MEM_W  = 2 * VTX_W + WEIGHT_BITS;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Action codes
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_RUN   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  edge_from;
        logic [5:0]  edge_to;
        logic [15:0] edge_weight;
        logic [5:0]  source_vertex;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [5:0]        vertex;
        logic [DIST_W-1:0] distance;
        logic              reachable;
        logic [5:0]        parent_vertex;
        logic              has_parent;
        logic              last;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic             take;
        logic             sel_step;
        logic             visit;
        logic             e_proc;
        logic             e_upd;
        logic             emit_step;
        logic             emit_load;
        logic             last;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic              run_start;
        logic              out_free;
        logic              found;
        logic [CNT_W-1:0]  n_act;
        logic [ECNT_W-1:0] edge_count;
    } sts_t;

endpackage

### rtl/core/ssp_datapath.sv
// Datapath: edge table, per-vertex state, selection scan and result register.
module ssp_datapath
    import ssp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_item_t   item,
    input  logic       cfg_valid,
    input  logic [6:0] cfg_data,
    input  logic       result_ready,
    output logic       result_valid,
    output out_item_t  result,
    input  cmd_t       cmd,
    output sts_t       sts
);

    // Configuration and edge table bookkeeping
    logic [CNT_W-1:0]  vc_reg;
    logic [CNT_W-1:0]  n_act;
    logic [ECNT_W-1:0] ecount_reg;

    // Edge memory and its registered read
    logic [MEM_W-1:0]  edge_mem [MAX_EDGES];
    logic [MEM_W-1:0]  rd_reg;

    // Per-vertex state
    logic [DIST_W-1:0] dist_reg [MAX_VERTICES];
    logic [VTX_W-1:0]  par_reg  [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] reached_reg, visited_reg, emitted_reg, hp_reg;

    // Scan state
    logic              found_reg, found_next;
    logic [VTX_W-1:0]  best_idx_reg, best_idx_next;
    logic [DIST_W:0]   best_key_reg, best_key_next;

    // Relaxation stage
    logic              ok_reg;
    logic [DIST_W-1:0] nd_reg;
    logic [VTX_W-1:0]  h_reg;

    logic              result_valid_reg;
    out_item_t         result_reg;

    logic [VTX_W-1:0]  v;
    logic              found_eff, cand, better;
    logic [DIST_W:0]   key_v;
    logic              src_ok, from_ok, to_ok, full, single_load, mem_we;
    logic [1:0]        single_status;
    logic [VTX_W-1:0]  rd_tail, rd_head;
    logic [WEIGHT_BITS-1:0] rd_w;
    logic [DIST_W:0]   sum;
    logic              relax;
    out_item_t         emit_item;

    assign n_act = (vc_reg > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vc_reg;
    assign v     = cmd.idx[VTX_W-1:0];

    // Item decode
    always_comb
    begin
        src_ok  = CNT_W'(item.source_vertex) < n_act;
        from_ok = CNT_W'(item.edge_from) < n_act;
        to_ok   = CNT_W'(item.edge_to) < n_act;
        full    = ecount_reg >= ECNT_W'(MAX_EDGES);
        single_status = ST_OK;
        single_load   = 1'b0;
        mem_we        = 1'b0;
        case (item.action)
            ACT_CLEAR:
            begin
                single_load = cmd.take;
            end
            ACT_ADD:
            begin
                single_load = cmd.take;
                if (!(from_ok && to_ok))
                    single_status = ST_RANGE;
                else if (full)
                    single_status = ST_FULL;
                else
                    mem_we = cmd.take;
            end
            ACT_RUN:
            begin
                single_load   = cmd.take && !src_ok;
                single_status = ST_RANGE;
            end
            default:
            begin
                single_load = 1'b0;
            end
        endcase
    end

    assign sts.run_start  = (item.action == ACT_RUN) && src_ok && (n_act > CNT_W'(1));
    assign sts.out_free   = !result_valid_reg || result_ready;
    assign sts.found      = found_reg;
    assign sts.n_act      = n_act;
    assign sts.edge_count = ecount_reg;

    // Minimum scan over vertices, one vertex a cycle
    always_comb
    begin
        found_eff = found_reg && (cmd.idx != '0);
        cand      = 1'b0;
        key_v     = {1'b0, dist_reg[v]};
        if (cmd.sel_step)
        begin
            cand  = reached_reg[v] && !visited_reg[v];
            key_v = {1'b0, dist_reg[v]};
        end
        else if (cmd.emit_step)
        begin
            cand  = !emitted_reg[v];
            key_v = reached_reg[v] ? {1'b0, dist_reg[v]} : {1'b1, {DIST_W{1'b0}}};
        end
        better        = !found_eff || (key_v < best_key_reg);
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_key_next = best_key_reg;
        if (cmd.sel_step || cmd.emit_step)
        begin
            found_next = found_eff || cand;
            if (cand && better)
            begin
                best_idx_next = v;
                best_key_next = key_v;
            end
        end
    end

    // Edge word and relaxed distance
    assign rd_tail = rd_reg[MEM_W-1 -: VTX_W];
    assign rd_head = rd_reg[WEIGHT_BITS +: VTX_W];
    assign rd_w    = rd_reg[WEIGHT_BITS-1:0];
    assign sum     = {1'b0, best_key_reg[DIST_W-1:0]} + (DIST_W+1)'(rd_w);
    assign relax   = ok_reg && (!reached_reg[h_reg] || (nd_reg < dist_reg[h_reg]));

    // Result of one emitted vertex
    always_comb
    begin
        emit_item               = '0;
        emit_item.status        = ST_OK;
        emit_item.vertex        = 6'(best_idx_reg);
        emit_item.reachable     = reached_reg[best_idx_reg];
        emit_item.distance      = reached_reg[best_idx_reg] ? dist_reg[best_idx_reg] : '0;
        emit_item.has_parent    = hp_reg[best_idx_reg];
        emit_item.parent_vertex = hp_reg[best_idx_reg] ? 6'(par_reg[best_idx_reg]) : 6'd0;
        emit_item.last          = cmd.last;
    end

    // Edge memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            edge_mem[ecount_reg[EDGE_W-1:0]] <= {item.edge_from[VTX_W-1:0],
                item.edge_to[VTX_W-1:0], item.edge_weight[WEIGHT_BITS-1:0]};
        rd_reg <= edge_mem[cmd.idx[EDGE_W-1:0]];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg           <= CNT_W'(16);
            ecount_reg       <= '0;
            result_valid_reg <= 1'b0;
            found_reg        <= 1'b0;
            ok_reg           <= 1'b0;
            reached_reg      <= '0;
            visited_reg      <= '0;
            emitted_reg      <= '0;
            hp_reg           <= '0;
        end
        else
        begin
            if (cfg_valid)
                vc_reg <= cfg_data;
            if (cmd.take && item.action == ACT_CLEAR)
                ecount_reg <= '0;
            else if (mem_we)
                ecount_reg <= ecount_reg + ECNT_W'(1);

            if (single_load || cmd.emit_load)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;

            found_reg <= found_next;
            if (cmd.e_proc)
                ok_reg <= (rd_tail == best_idx_reg) && (CNT_W'(rd_tail) < n_act)
                          && (CNT_W'(rd_head) < n_act);

            // run start: only the source is reached and already emitted
            if (cmd.take && sts.run_start)
            begin
                reached_reg <= MAX_VERTICES'(1) << item.source_vertex[VTX_W-1:0];
                visited_reg <= '0;
                emitted_reg <= MAX_VERTICES'(1) << item.source_vertex[VTX_W-1:0];
                hp_reg      <= '0;
            end
            else
            begin
                if (cmd.visit)
                    visited_reg[best_idx_reg] <= 1'b1;
                if (cmd.e_upd && relax)
                begin
                    reached_reg[h_reg] <= 1'b1;
                    hp_reg[h_reg]      <= 1'b1;
                end
                if (cmd.emit_load)
                    emitted_reg[best_idx_reg] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_key_reg <= best_key_next;
        if (cmd.e_proc)
        begin
            nd_reg <= sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
            h_reg  <= rd_head;
        end
        if (cmd.take && sts.run_start)
            dist_reg[item.source_vertex[VTX_W-1:0]] <= '0;
        else if (cmd.e_upd && relax)
        begin
            dist_reg[h_reg] <= nd_reg;
            par_reg[h_reg]  <= best_idx_reg;
        end
        if (single_load)
            result_reg <= '{status: single_status, last: 1'b1, default: '0};
        else if (cmd.emit_load)
            result_reg <= emit_item;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

### rtl/core/ssp_ctrl.sv
// Controller: sequences item intake, vertex selection, edge relaxation and emission.
`include "assert_macros.svh"

module ssp_ctrl
    import ssp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic item_valid,
    output logic item_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SEL   = 3'd1;
    localparam logic [2:0] ST_VISIT = 3'd2;
    localparam logic [2:0] ST_ERD   = 3'd3;
    localparam logic [2:0] ST_EPRC  = 3'd4;
    localparam logic [2:0] ST_EUPD  = 3'd5;
    localparam logic [2:0] ST_ESEL  = 3'd6;
    localparam logic [2:0] ST_EOUT  = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [VTX_W-1:0] cnt_reg, cnt_next;
    logic             vtx_last, edge_last, emit_last;

    assign vtx_last  = CNT_W'(idx_reg) == (sts.n_act - CNT_W'(1));
    assign edge_last = ECNT_W'(idx_reg) == (sts.edge_count - ECNT_W'(1));
    assign emit_last = CNT_W'(cnt_reg) == (sts.n_act - CNT_W'(2));

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        item_ready = 1'b0;
        cmd        = '0;
        cmd.idx    = idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = sts.out_free;
                cmd.take   = item_valid && sts.out_free;
                if (cmd.take && sts.run_start)
                begin
                    state_next = ST_SEL;
                    idx_next   = '0;
                end
            end
            ST_SEL:
            begin
                cmd.sel_step = 1'b1;
                if (vtx_last)
                    state_next = ST_VISIT;
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            ST_VISIT:
            begin
                idx_next = '0;
                if (sts.found)
                begin
                    cmd.visit  = 1'b1;
                    state_next = (sts.edge_count == '0) ? ST_SEL : ST_ERD;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = ST_ESEL;
                end
            end
            ST_ERD:
            begin
                state_next = ST_EPRC;
            end
            ST_EPRC:
            begin
                cmd.e_proc = 1'b1;
                state_next = ST_EUPD;
            end
            ST_EUPD:
            begin
                cmd.e_upd = 1'b1;
                if (edge_last)
                begin
                    idx_next   = '0;
                    state_next = ST_SEL;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_ERD;
                end
            end
            ST_ESEL:
            begin
                cmd.emit_step = 1'b1;
                if (vtx_last)
                    state_next = ST_EOUT;
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
            ST_EOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    cmd.last      = emit_last;
                    idx_next      = '0;
                    cnt_next      = cnt_reg + VTX_W'(1);
                    state_next    = emit_last ? ST_IDLE : ST_ESEL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Checks
    `ASSERT_IMP(a_emit_room, clk, rst_n, cmd.emit_load, sts.out_free)
    `ASSERT_IMP(a_sel_range, clk, rst_n, state_reg == ST_SEL, CNT_W'(idx_reg) < sts.n_act)
    `ASSERT_NXT(a_last_done, clk, rst_n, cmd.emit_load && cmd.last, state_reg == ST_IDLE)
    `ASSERT_IMP(a_edges_seen, clk, rst_n, state_reg == ST_EUPD, sts.edge_count != '0)

endmodule

### rtl/core/single_source_shortest_path_unit.sv
// Edge loads and clear are handled in the idle state; a result register holds each result item.
// A run item scans all vertices to select each vertex it expands, then reads, processes
// and updates every stored edge; when none is left, it scans again for each emitted vertex.
// Result stalls add to this, and the single shared scan and edge memory port set the pace.
// Reset (asynchronous, active low) empties the edge table and sets vertex_count to 16.
// Edge table contents are undefined until written.
module single_source_shortest_path_unit
    import ssp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  in_item_t   item,
    output logic       result_valid,
    input  logic       result_ready,
    output out_item_t  result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [6:0] cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    ssp_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    ssp_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule
